/* design/ntca_pkg.sv */
`default_nettype none
package ntca_pkg;

    localparam int unsigned STEP_COUNT = 24;
    localparam logic [63:0] SAT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] TOPO_RING  = 2'd0;
    localparam logic [1:0] TOPO_MESH  = 2'd1;
    localparam logic [1:0] TOPO_TORUS = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_XFER = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [2:0] REG_TOPOLOGY            = 3'd0;
    localparam logic [2:0] REG_MAX_PACKET_BYTES    = 3'd1;
    localparam logic [2:0] REG_TIME_PER_PACKET     = 3'd2;
    localparam logic [2:0] REG_TIME_PER_HOP        = 3'd3;
    localparam logic [2:0] REG_TIME_PER_BYTE_HOP   = 3'd4;
    localparam logic [2:0] REG_ENERGY_PER_PACKET   = 3'd5;
    localparam logic [2:0] REG_ENERGY_PER_HOP      = 3'd6;
    localparam logic [2:0] REG_ENERGY_PER_BYTE_HOP = 3'd7;

    typedef struct packed {
        logic        func;
        logic [3:0]  src_socket;
        logic [3:0]  dst_socket;
        logic [3:0]  pos_x;
        logic [3:0]  pos_y;
        logic [23:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  hop_count;
        logic [63:0] time_cost;
        logic [63:0] energy_cost;
        logic [63:0] time_total;
        logic [63:0] energy_total;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic tbl_write;
        logic lookup;
        logic start;
        logic div_step;
        logic mul_start;
        logic mul_step;
        logic combine;
        logic clear_cost;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic lookup_err;
    } dp_status_t;

endpackage
`default_nettype wire

/* design/ntca_ctrl.sv */
`default_nettype none
module ntca_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire ntca_pkg::dp_status_t stat,
    output ntca_pkg::dp_cmd_t         cmd
);
    import ntca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_START, ST_DIV, ST_MULSTART, ST_MUL, ST_COMBINE, ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (stat.func == FUNC_LOAD) begin
                    cmd.tbl_write  = 1'b1;
                    cmd.clear_cost = 1'b1;
                    state_next     = ST_FINISH;
                end else begin
                    cmd.lookup = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.lookup_err) begin
                    cmd.clear_cost = 1'b1;
                    state_next     = ST_FINISH;
                end else begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEP_COUNT - 1)) begin
                    state_next = ST_MULSTART;
                end
            end
            ST_MULSTART: begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEP_COUNT - 1)) begin
                    state_next = ST_COMBINE;
                end
            end
            ST_COMBINE: begin
                cmd.combine = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

/* design/ntca_datapath.sv */
`default_nettype none
module ntca_datapath #(
    parameter int GRID_COLUMNS = 4,
    parameter int GRID_ROWS    = 4,
    parameter int SOCKET_COUNT = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ntca_pkg::in_item_t   s_item,
    output ntca_pkg::out_item_t       m_item,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire ntca_pkg::dp_cmd_t    cmd,
    output ntca_pkg::dp_status_t      stat
);
    import ntca_pkg::*;

    localparam int SOCK_W = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
    localparam logic [8:0] COLS9  = 9'(GRID_COLUMNS);
    localparam logic [8:0] CELLS9 = 9'(GRID_COLUMNS * GRID_ROWS);
    localparam logic [4:0] COLS5  = 5'(GRID_COLUMNS);
    localparam logic [4:0] ROWS5  = 5'(GRID_ROWS);

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT_MAX : s[63:0];
    endfunction

    // configuration
    logic [1:0]  topo_reg;
    logic [15:0] mpb_reg, tpp_reg, tph_reg, tpb_reg;
    logic [31:0] epp_reg, eph_reg, epb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            topo_reg <= TOPO_MESH;
            mpb_reg  <= 16'd64;
            tpp_reg  <= '0;
            tph_reg  <= '0;
            tpb_reg  <= '0;
            epp_reg  <= '0;
            eph_reg  <= '0;
            epb_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOPOLOGY:            topo_reg <= cfg_data[1:0];
                REG_MAX_PACKET_BYTES:    mpb_reg  <= cfg_data[15:0];
                REG_TIME_PER_PACKET:     tpp_reg  <= cfg_data[15:0];
                REG_TIME_PER_HOP:        tph_reg  <= cfg_data[15:0];
                REG_TIME_PER_BYTE_HOP:   tpb_reg  <= cfg_data[15:0];
                REG_ENERGY_PER_PACKET:   epp_reg  <= cfg_data;
                REG_ENERGY_PER_HOP:      eph_reg  <= cfg_data;
                REG_ENERGY_PER_BYTE_HOP: epb_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // accepted item
    in_item_t item_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
    end

    // position table: {row, column} per socket
    logic [7:0]              pos_mem [SOCKET_COUNT];
    logic [SOCKET_COUNT-1:0] pos_valid_reg;
    logic [7:0]              src_pos_reg, dst_pos_reg;
    logic                    err_reg;
    logic [SOCK_W-1:0]       src_idx, dst_idx;
    logic                    src_ok, dst_ok;

    assign src_idx = SOCK_W'(item_reg.src_socket);
    assign dst_idx = SOCK_W'(item_reg.dst_socket);
    assign src_ok  = (32'(item_reg.src_socket) < SOCKET_COUNT);
    assign dst_ok  = (32'(item_reg.dst_socket) < SOCKET_COUNT);

    always_ff @(posedge aclk) begin
        if (cmd.tbl_write && src_ok && (32'(item_reg.pos_x) < GRID_COLUMNS)
            && (32'(item_reg.pos_y) < GRID_ROWS)) begin
            pos_mem[src_idx] <= {item_reg.pos_y, item_reg.pos_x};
        end
        if (cmd.lookup) begin
            src_pos_reg <= pos_mem[src_idx];
            dst_pos_reg <= pos_mem[dst_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_valid_reg <= '0;
            err_reg       <= 1'b0;
        end else begin
            if (cmd.tbl_write && src_ok && (32'(item_reg.pos_x) < GRID_COLUMNS)
                && (32'(item_reg.pos_y) < GRID_ROWS)) begin
                pos_valid_reg[src_idx] <= 1'b1;
            end
            if (cmd.lookup) begin
                err_reg <= !(src_ok && dst_ok && pos_valid_reg[src_idx]
                             && pos_valid_reg[dst_idx]);
            end
        end
    end

    assign stat.func       = item_reg.func;
    assign stat.lookup_err = err_reg;

    // hop count
    logic [3:0] fx, fy, tx, ty, dx, dy;
    logic [8:0] ra, rb, rd, rnd;
    logic [4:0] cdx, rdy, hx, hy;
    logic [7:0] hops_calc;

    assign fx = src_pos_reg[3:0];
    assign fy = src_pos_reg[7:4];
    assign tx = dst_pos_reg[3:0];
    assign ty = dst_pos_reg[7:4];
    assign dx = (fx > tx) ? fx - tx : tx - fx;
    assign dy = (fy > ty) ? fy - ty : ty - fy;

    always_comb begin
        ra  = 9'(fx) + COLS9 * 9'(fy);
        rb  = 9'(tx) + COLS9 * 9'(ty);
        rd  = (ra > rb) ? ra - rb : rb - ra;
        rnd = (CELLS9 > rd) ? CELLS9 - rd : rd - CELLS9;
        cdx = COLS5 - 5'(dx);
        rdy = ROWS5 - 5'(dy);
        hx  = (5'(dx) < cdx) ? 5'(dx) : cdx;
        hy  = (5'(dy) < rdy) ? 5'(dy) : rdy;
        unique case (topo_reg)
            TOPO_RING:  hops_calc = 8'((rd < rnd) ? rd : rnd);
            TOPO_TORUS: hops_calc = 8'(hx) + 8'(hy);
            default:    hops_calc = 8'(dx) + 8'(dy);
        endcase
    end

    // restoring divider, one quotient bit per step
    logic [15:0] len_reg, rem_reg;
    logic [23:0] q_reg;
    logic [17:0] div_diff;
    logic [7:0]  hops_reg;
    logic [15:0] bytes_reg;

    assign div_diff = {1'b0, rem_reg, q_reg[23]} - {2'b0, len_reg};

    // per-packet cost pipeline, free running on bytes_reg and hops_reg
    logic [31:0] tp1_reg;
    logic [47:0] ep1_reg;
    logic [32:0] tper_reg;
    logic [48:0] eper_reg;
    logic [40:0] tm_reg;
    logic [56:0] em_reg;
    logic [41:0] tc_reg;
    logic [57:0] ec_reg;

    always_ff @(posedge aclk) begin
        tp1_reg  <= 32'(tpb_reg) * 32'(bytes_reg);
        ep1_reg  <= 48'(epb_reg) * 48'(bytes_reg);
        tper_reg <= 33'(tph_reg) + 33'(tp1_reg);
        eper_reg <= 49'(eph_reg) + 49'(ep1_reg);
        tm_reg   <= 41'(tper_reg) * 41'(hops_reg);
        em_reg   <= 57'(eper_reg) * 57'(hops_reg);
        tc_reg   <= 42'(tpp_reg) + 42'(tm_reg);
        ec_reg   <= 58'(epp_reg) + 58'(em_reg);
    end

    // serial saturating multipliers for full packets, msb first
    logic [63:0] ta_reg, ea_reg, tacc_reg, eacc_reg;
    logic        tsat_reg, esat_reg;
    logic [23:0] mb_reg;
    logic [65:0] tstep, estep;
    logic [63:0] tfull, efull, tres, eres;

    assign tstep = {1'b0, tacc_reg, 1'b0} + (mb_reg[23] ? {2'b0, ta_reg} : 66'd0);
    assign estep = {1'b0, eacc_reg, 1'b0} + (mb_reg[23] ? {2'b0, ea_reg} : 66'd0);
    assign tfull = tsat_reg ? SAT_MAX : tacc_reg;
    assign efull = esat_reg ? SAT_MAX : eacc_reg;
    assign tres  = (rem_reg != 16'd0) ? 64'(tc_reg) : 64'd0;
    assign eres  = (rem_reg != 16'd0) ? 64'(ec_reg) : 64'd0;

    logic        status_reg;
    logic [63:0] tcost_reg, ecost_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hops_reg  <= hops_calc;
            len_reg   <= (mpb_reg == 16'd0) ? 16'd1 : mpb_reg;
            bytes_reg <= (mpb_reg == 16'd0) ? 16'd1 : mpb_reg;
            q_reg     <= item_reg.byte_count;
            rem_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (!div_diff[17]) begin
                rem_reg <= div_diff[15:0];
                q_reg   <= {q_reg[22:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[14:0], q_reg[23]};
                q_reg   <= {q_reg[22:0], 1'b0};
            end
        end
        if (cmd.mul_start) begin
            ta_reg    <= 64'(tc_reg);
            ea_reg    <= 64'(ec_reg);
            mb_reg    <= q_reg;
            tacc_reg  <= '0;
            eacc_reg  <= '0;
            tsat_reg  <= 1'b0;
            esat_reg  <= 1'b0;
            bytes_reg <= rem_reg;
        end
        if (cmd.mul_step) begin
            tacc_reg <= tstep[63:0];
            eacc_reg <= estep[63:0];
            tsat_reg <= tsat_reg || (tstep[65:64] != 2'b00);
            esat_reg <= esat_reg || (estep[65:64] != 2'b00);
            mb_reg   <= {mb_reg[22:0], 1'b0};
        end
        if (cmd.combine) begin
            tcost_reg  <= sat_add(tfull, tres);
            ecost_reg  <= sat_add(efull, eres);
            status_reg <= STATUS_OK;
        end
        if (cmd.clear_cost) begin
            tcost_reg  <= '0;
            ecost_reg  <= '0;
            hops_reg   <= '0;
            status_reg <= (item_reg.func == FUNC_XFER) ? err_reg : STATUS_OK;
        end
    end

    // running totals and result register
    logic [63:0] tsum_reg, esum_reg, tsum_next, esum_next;
    out_item_t   out_reg;

    assign tsum_next = sat_add(tsum_reg, tcost_reg);
    assign esum_next = sat_add(esum_reg, ecost_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsum_reg <= '0;
            esum_reg <= '0;
        end else if (cmd.out_load) begin
            tsum_reg <= tsum_next;
            esum_reg <= esum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= status_reg;
            out_reg.hop_count    <= hops_reg;
            out_reg.time_cost    <= tcost_reg;
            out_reg.energy_cost  <= ecost_reg;
            out_reg.time_total   <= tsum_next;
            out_reg.energy_total <= esum_next;
        end
    end

    assign m_item = out_reg;

endmodule
`default_nettype wire

/* design/noc_transfer_cost_accounting_top.sv */
// NoC transfer cost accounting.
// Input items arrive on s_valid/s_ready/s_item. func 0 loads the grid position of a
// socket into the position table; func 1 logs a transfer and returns its hop count,
// time and energy cost and the updated saturating totals. Every item yields one
// result on m_valid/m_ready/m_item.
// Cost registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no item is in flight, as the block does not enforce it. A write
// takes effect at the same clock edge. One item is worked on at a time. A transfer's
// result waits on the 24-step restoring divider that splits the size into packets
// and the 24-step serial multiplier that scales the full-packet cost. s_ready is high
// only while no item is in work, so the block takes no new item before the last
// item's result is loaded.
// The result register frees the engine from the receiver: a new item is accepted
// while a result waits; the next result is held back until m_ready takes the old one.
// Reset (aresetn low, synchronous) restores register defaults, marks all table
// entries unloaded and clears both totals. No clearing pass is needed.
`default_nettype none
module noc_transfer_cost_accounting_top #(
    parameter int GRID_COLUMNS = 4,
    parameter int GRID_ROWS    = 4,
    parameter int SOCKET_COUNT = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ntca_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ntca_pkg::out_item_t      m_item,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import ntca_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    ntca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ntca_datapath #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS),
        .SOCKET_COUNT (SOCKET_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

/* verif/noc_transfer_cost_accounting_top_tb.sv */
`default_nettype none
module noc_transfer_cost_accounting_top_tb;
    import ntca_pkg::*;

    localparam int COLS = 4;
    localparam int ROWS = 4;
    localparam int SOCKETS = 16;
    localparam int XFER_LATENCY = 60;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    noc_transfer_cost_accounting_top #(
        .GRID_COLUMNS(COLS),
        .GRID_ROWS(ROWS),
        .SOCKET_COUNT(SOCKETS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the block's registers and state
    logic [1:0]  topo;
    logic [15:0] pkt_len;
    logic [15:0] t_pkt, t_hop, t_byte;
    logic [31:0] e_pkt, e_hop, e_byte;
    logic        pos_loaded [SOCKETS];
    logic [3:0]  pos_col [SOCKETS];
    logic [3:0]  pos_row [SOCKETS];
    logic [63:0] time_acc, energy_acc;

    out_item_t   expected_results [$];
    int          error_count;
    longint      cycle_count;
    bit          hold_off;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("noc_transfer_cost_accounting_top test failed");
            $finish;
        end
    end

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT_MAX : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? SAT_MAX : p[63:0];
    endfunction

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic int unsigned min_u(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    function automatic int unsigned hop_distance(int unsigned fx, int unsigned fy,
                                                 int unsigned tx, int unsigned ty);
        int unsigned dx, dy, d;
        dx = abs_diff(fx, tx);
        dy = abs_diff(fy, ty);
        if (topo == TOPO_RING) begin
            d = abs_diff(fx + COLS * fy, tx + COLS * ty);
            return min_u(d, abs_diff(COLS * ROWS, d));
        end
        if (topo == TOPO_TORUS)
            return min_u(dx, abs_diff(COLS, dx)) + min_u(dy, abs_diff(ROWS, dy));
        return dx + dy;
    endfunction

    function automatic logic [63:0] one_packet_cost(logic [63:0] per_pkt, logic [63:0] per_hop,
            logic [63:0] per_byte, logic [63:0] hops, logic [63:0] nbytes);
        return sat_add(per_pkt, sat_mul(hops, sat_add(per_hop, sat_mul(per_byte, nbytes))));
    endfunction

    function automatic out_item_t predict_cost(in_item_t it);
        out_item_t r;
        logic [63:0] len, full, resid, h;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            if (it.src_socket < SOCKETS && it.pos_x < COLS && it.pos_y < ROWS) begin
                pos_loaded[it.src_socket] = 1'b1;
                pos_col[it.src_socket] = it.pos_x;
                pos_row[it.src_socket] = it.pos_y;
            end
        end else if (it.src_socket >= SOCKETS || it.dst_socket >= SOCKETS ||
                     !pos_loaded[it.src_socket] || !pos_loaded[it.dst_socket]) begin
            r.status = STATUS_ERR;
        end else begin
            len = (pkt_len == 0) ? 64'd1 : 64'(pkt_len);
            full = 64'(it.byte_count) / len;
            resid = 64'(it.byte_count) % len;
            h = 64'(hop_distance(32'(pos_col[it.src_socket]), 32'(pos_row[it.src_socket]),
                                 32'(pos_col[it.dst_socket]), 32'(pos_row[it.dst_socket])));
            r.hop_count = h[7:0];
            r.time_cost = sat_mul(full, one_packet_cost(64'(t_pkt), 64'(t_hop),
                                                        64'(t_byte), h, len));
            r.energy_cost = sat_mul(full, one_packet_cost(64'(e_pkt), 64'(e_hop),
                                                          64'(e_byte), h, len));
            if (resid != 0) begin
                r.time_cost = sat_add(r.time_cost,
                    one_packet_cost(64'(t_pkt), 64'(t_hop), 64'(t_byte), h, resid));
                r.energy_cost = sat_add(r.energy_cost,
                    one_packet_cost(64'(e_pkt), 64'(e_hop), 64'(e_byte), h, resid));
            end
            time_acc = sat_add(time_acc, r.time_cost);
            energy_acc = sat_add(energy_acc, r.energy_cost);
        end
        r.time_total = time_acc;
        r.energy_total = energy_acc;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_item);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_item.status !== want.status)
                    $display("%0t: status exp %h got %h", $time, want.status, m_item.status);
                if (m_item.hop_count !== want.hop_count)
                    $display("%0t: hop_count exp %0d got %0d", $time, want.hop_count,
                             m_item.hop_count);
                if (m_item.time_cost !== want.time_cost)
                    $display("%0t: time_cost exp %h got %h", $time, want.time_cost,
                             m_item.time_cost);
                if (m_item.energy_cost !== want.energy_cost)
                    $display("%0t: energy_cost exp %h got %h", $time, want.energy_cost,
                             m_item.energy_cost);
                if (m_item.time_total !== want.time_total)
                    $display("%0t: time_total exp %h got %h", $time, want.time_total,
                             m_item.time_total);
                if (m_item.energy_total !== want.energy_total)
                    $display("%0t: energy_total exp %h got %h", $time, want.energy_total,
                             m_item.energy_total);
                if (m_item !== want)
                    error_count++;
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (m_ready && !m_valid) begin
                m_ready <= 1'b1;
            end else if (m_ready) begin
                // item waiting: draw a wait before taking it
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(in_item_t it, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 4) == 0) gap = 0;
        // the block stays busy for a while after taking an item
        @(negedge aclk);
        repeat (gap) @(negedge aclk);
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_cost(it));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (XFER_LATENCY) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TOPOLOGY:            topo = val[1:0];
            REG_MAX_PACKET_BYTES:    pkt_len = val[15:0];
            REG_TIME_PER_PACKET:     t_pkt = val[15:0];
            REG_TIME_PER_HOP:        t_hop = val[15:0];
            REG_TIME_PER_BYTE_HOP:   t_byte = val[15:0];
            REG_ENERGY_PER_PACKET:   e_pkt = val;
            REG_ENERGY_PER_HOP:      e_hop = val;
            default:                 e_byte = val;
        endcase
    endtask

    function automatic in_item_t make_load(int s, int x, int y);
        in_item_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.src_socket = 4'(s);
        it.pos_x = 4'(x);
        it.pos_y = 4'(y);
        it.dst_socket = 4'($urandom);
        it.byte_count = 24'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_xfer(int s, int d, int n);
        in_item_t it;
        it = '0;
        it.func = FUNC_XFER;
        it.src_socket = 4'(s);
        it.dst_socket = 4'(d);
        it.byte_count = 24'(n);
        it.pos_x = 4'($urandom);
        it.pos_y = 4'($urandom);
        return it;
    endfunction

    // mostly small sizes keep the cost numbers interesting
    function automatic int rand_size();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 24'hFFFFFF - $urandom_range(0, 3);
            2: return $urandom;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    task automatic random_costs(bit huge);
        write_reg(REG_MAX_PACKET_BYTES, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 300));
        write_reg(REG_TIME_PER_PACKET, huge ? 16'hFFFF : $urandom_range(0, 50));
        write_reg(REG_TIME_PER_HOP, huge ? $urandom : $urandom_range(0, 20));
        write_reg(REG_TIME_PER_BYTE_HOP, huge ? 16'hFFFF : $urandom_range(0, 5));
        write_reg(REG_ENERGY_PER_PACKET, huge ? 32'hFFFFFFFF : $urandom);
        write_reg(REG_ENERGY_PER_HOP, $urandom);
        write_reg(REG_ENERGY_PER_BYTE_HOP, huge ? 32'hFFFFFFFF : $urandom_range(0, 1 << 20));
    endtask

    task automatic test_unloaded_table();
        send_item(make_xfer(0, 1, 100));
        send_item(make_xfer(15, 15, 0));
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_TOPOLOGY, TOPO_MESH);
        write_reg(REG_MAX_PACKET_BYTES, 16);
        write_reg(REG_TIME_PER_PACKET, 10);
        write_reg(REG_TIME_PER_HOP, 3);
        write_reg(REG_TIME_PER_BYTE_HOP, 1);
        write_reg(REG_ENERGY_PER_PACKET, 32'h0001_8000);
        write_reg(REG_ENERGY_PER_HOP, 32'h0000_4000);
        write_reg(REG_ENERGY_PER_BYTE_HOP, 32'h0000_0100);
        send_item(make_load(0, 0, 0));
        send_item(make_load(15, 3, 3));
        send_item(make_load(5, 4, 0));   // column off the grid
        send_item(make_load(6, 0, 15));  // row off the grid
        send_item(make_xfer(0, 15, 40));
        send_item(make_xfer(0, 5, 40));  // unknown socket
        send_item(make_xfer(15, 0, 0));  // zero bytes
        send_item(make_xfer(0, 15, 24'hFFFFFF));
        send_item(make_xfer(0, 0, 33));
        send_item(make_load(15, 1, 2));
        send_item(make_xfer(15, 0, 32));
        drain();
        write_reg(REG_TOPOLOGY, 2'd3);   // code 3 counts as mesh
        send_item(make_xfer(0, 15, 17));
        drain();
        write_reg(REG_TOPOLOGY, TOPO_RING);
        write_reg(REG_MAX_PACKET_BYTES, 0);
        send_item(make_xfer(0, 15, 5));
        drain();
        write_reg(REG_TOPOLOGY, TOPO_TORUS);
        write_reg(REG_MAX_PACKET_BYTES, 16'hFFFF);
        send_item(make_xfer(0, 15, 24'hFFFFFF));
        drain();
    endtask

    task automatic random_phase(int n, bit no_gap);
        int s, d;
        repeat (n) begin
            if ($urandom_range(0, 9) < 3)
                send_item(make_load($urandom_range(0, 15), $urandom_range(0, 15) % 5,
                                    $urandom_range(0, 15) % 5), no_gap);
            else begin
                s = $urandom_range(0, 15);
                d = $urandom_range(0, 15);
                send_item(make_xfer(s, d, rand_size()), no_gap);
            end
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_TOPOLOGY, ph % 4);
            random_costs(ph % 4 == 3);
            random_phase(120, 1'b0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            random_phase(8, 1'b1);
        join
        drain();
    endtask

    task automatic test_saturation();
        write_reg(REG_TOPOLOGY, TOPO_MESH);
        write_reg(REG_MAX_PACKET_BYTES, 1);
        write_reg(REG_TIME_PER_PACKET, 16'hFFFF);
        write_reg(REG_TIME_PER_HOP, 16'hFFFF);
        write_reg(REG_TIME_PER_BYTE_HOP, 16'hFFFF);
        write_reg(REG_ENERGY_PER_PACKET, 32'hFFFFFFFF);
        write_reg(REG_ENERGY_PER_HOP, 32'hFFFFFFFF);
        write_reg(REG_ENERGY_PER_BYTE_HOP, 32'hFFFFFFFF);
        send_item(make_load(1, 0, 0));
        send_item(make_load(2, 3, 3));
        repeat (6) send_item(make_xfer(1, 2, 24'hFFFFFF));
        drain();
        random_phase(60, 1'b0);
        drain();
    endtask

    initial begin
        s_valid = 1'b0;
        s_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        hold_off = 1'b0;
        error_count = 0;
        cycle_count = 0;
        topo = TOPO_MESH;
        pkt_len = 16'd64;
        {t_pkt, t_hop, t_byte} = '0;
        {e_pkt, e_hop, e_byte} = '0;
        time_acc = '0;
        energy_acc = '0;
        for (int i = 0; i < SOCKETS; i++) begin
            pos_loaded[i] = 1'b0;
            pos_col[i] = '0;
            pos_row[i] = '0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_unloaded_table();
        test_directed();
        test_random();
        test_backpressure();
        test_saturation();

        drain();
        if (error_count == 0 && expected_results.size() == 0)
            $display("noc_transfer_cost_accounting_top test passed");
        else
            $display("noc_transfer_cost_accounting_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
